[design/prime_factor_sieve_top_assert.svh]
// Assertion macros for the factor sieve block.
`ifndef PRIME_FACTOR_SIEVE_TOP_ASSERT_SVH
`define PRIME_FACTOR_SIEVE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PFS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFS_ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define PFS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PFS_ASSERT_CHK(label, clk, rst_n, prop, msg)
`endif

`endif

[design/pfs_pkg.sv]
package pfs_pkg;

  localparam int VALUE_BITS  = 20;
  localparam int MAX_RESULTS = 7;
  localparam int DEPTH       = 1 << VALUE_BITS;
  localparam int HALF_BITS   = (VALUE_BITS + 1) / 2;
  localparam int J_BITS      = 2 * HALF_BITS + 1;
  localparam int EXP_BITS    = $clog2(VALUE_BITS + 1);
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int DIV_BITS    = $clog2(VALUE_BITS);
  localparam int STAT_BITS   = 2;

  localparam logic [STAT_BITS-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_ONE = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_ERR = 2'd2;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_ONE,
    KIND_FACT
  } kind_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    kind_t                 kind;
  } qitem_t;

  typedef struct packed {
    logic                  wr;
    logic [VALUE_BITS-1:0] limit;
  } cfg_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_SV_RD,
    S_SV_WT,
    S_MK_RD,
    S_MK_WT,
    S_START,
    S_SINGLE,
    S_F_RD,
    S_F_WT,
    S_DIV
  } state_t;

endpackage

[design/pfs_queue.sv]
module pfs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pfs_pkg::qitem_t push_data,
  input  logic            pop,
  output pfs_pkg::qitem_t head,
  output logic            empty,
  output logic            full
);
  import pfs_pkg::*;

  // two-entry FIFO
  qitem_t      mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

[design/pfs_front.sv]
module pfs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfs_pkg::VALUE_BITS-1:0] in_query_value,
  input  logic                           cfg_wr_en,
  input  logic [pfs_pkg::VALUE_BITS-1:0] cfg_wr_data,
  input  logic                           q_full,
  output logic                           q_push,
  output pfs_pkg::qitem_t                q_data,
  output pfs_pkg::cfg_ctl_t              cfg_ctl
);
  import pfs_pkg::*;

  logic [VALUE_BITS-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  assign cfg_ctl.wr    = cfg_wr_en;
  assign cfg_ctl.limit = limit_r;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify: zero or past limit is an error, one has no factors
  always_comb begin
    q_data.value = in_query_value;
    if (in_query_value == '0 || in_query_value > limit_r) begin
      q_data.kind = KIND_ERR;
    end else if (in_query_value == VALUE_BITS'(1)) begin
      q_data.kind = KIND_ONE;
    end else begin
      q_data.kind = KIND_FACT;
    end
  end

endmodule

[design/pfs_back.sv]
module pfs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pfs_pkg::cfg_ctl_t              cfg_ctl,
  input  pfs_pkg::qitem_t                q_head,
  input  logic                           q_empty,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfs_pkg::VALUE_BITS-1:0] out_prime_factor,
  output logic [pfs_pkg::EXP_BITS-1:0]   out_exponent,
  output logic                           out_value_is_prime,
  output logic [pfs_pkg::STAT_BITS-1:0]  out_status,
  output logic                           out_last
);
  import pfs_pkg::*;

  // smallest-factor table
  logic [VALUE_BITS-1:0] tbl [DEPTH];
  logic                  we, re;
  logic [VALUE_BITS-1:0] waddr, wdata, raddr, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      tbl[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= tbl[raddr];
    end
  end

  state_t                state_r, state_nxt;
  logic                  built_r;
  qitem_t                item_r;
  logic [VALUE_BITS:0]   i_r;
  logic [J_BITS-1:0]     j_r;
  logic [VALUE_BITS-1:0] x_r, cur_p_r, dvd_r;
  logic [VALUE_BITS:0]   rem_r, rem_t, rem_s;
  logic [DIV_BITS-1:0]   dcnt_r;
  logic [EXP_BITS-1:0]   e_r;
  logic [CNT_BITS-1:0]   n_r;
  logic                  isp_r;
  logic                  out_free;
  logic                  need_emit, emit_last, fin_last;
  logic [VALUE_BITS:0]   lim_ext;
  logic [J_BITS-1:0]     lim_j;

  assign lim_ext  = {1'b0, cfg_ctl.limit};
  assign lim_j    = J_BITS'(cfg_ctl.limit);
  assign out_free = !out_valid || !out_stall;
  assign rem_t    = {rem_r[VALUE_BITS-1:0], dvd_r[VALUE_BITS-1]};
  assign rem_s    = rem_t - {1'b0, cur_p_r};

  assign need_emit = (x_r == VALUE_BITS'(1)) || (rdata_r != cur_p_r && cur_p_r != '0);
  assign emit_last = (n_r == CNT_BITS'(MAX_RESULTS - 1));
  assign fin_last  = (x_r == VALUE_BITS'(1)) || emit_last;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (!q_empty) state_nxt = built_r ? S_START : S_CLR;
      S_CLR:    if (j_r == lim_j) state_nxt = S_SV_RD;
      S_SV_RD:  state_nxt = (i_r > lim_ext) ? S_START : S_SV_WT;
      S_SV_WT: begin
        if (rdata_r == '0 && i_r[VALUE_BITS:HALF_BITS] == '0) begin
          state_nxt = S_MK_RD;
        end else begin
          state_nxt = S_SV_RD;
        end
      end
      S_MK_RD:  state_nxt = (j_r > lim_j) ? S_SV_RD : S_MK_WT;
      S_MK_WT:  state_nxt = S_MK_RD;
      S_START:  state_nxt = (item_r.kind == KIND_FACT) ? S_F_RD : S_SINGLE;
      S_SINGLE: if (out_free) state_nxt = S_IDLE;
      S_F_RD:   state_nxt = S_F_WT;
      S_F_WT: begin
        if (!(need_emit && !out_free)) begin
          if (need_emit && fin_last) state_nxt = S_IDLE;
          else                       state_nxt = S_DIV;
        end
      end
      S_DIV:    if (dcnt_r == DIV_BITS'(VALUE_BITS - 1)) state_nxt = S_F_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = j_r[VALUE_BITS-1:0];
    wdata = '0;
    raddr = x_r;
    case (state_r)
      S_CLR: we = 1'b1;
      S_SV_RD: begin
        re    = !(i_r > lim_ext);
        raddr = i_r[VALUE_BITS-1:0];
      end
      S_SV_WT: begin
        we    = (rdata_r == '0);
        waddr = i_r[VALUE_BITS-1:0];
        wdata = i_r[VALUE_BITS-1:0];
      end
      S_MK_RD: begin
        re    = !(j_r > lim_j);
        raddr = j_r[VALUE_BITS-1:0];
      end
      S_MK_WT: begin
        we    = (rdata_r == '0);
        wdata = i_r[VALUE_BITS-1:0];
      end
      S_F_RD:  re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      built_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ctl.wr) begin
        built_r <= 1'b0;
      end else if (state_r == S_SV_RD && i_r > lim_ext) begin
        built_r <= 1'b1;
      end
      if ((state_r == S_SINGLE && out_free) ||
          (state_r == S_F_WT && need_emit && out_free)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        item_r <= q_head;
        j_r    <= '0;
      end
      S_CLR: begin
        j_r <= j_r + J_BITS'(1);
        i_r <= (VALUE_BITS + 1)'(2);
      end
      S_SV_WT: begin
        j_r <= J_BITS'(i_r[HALF_BITS-1:0]) * J_BITS'(i_r[HALF_BITS-1:0]);
        if (!(rdata_r == '0 && i_r[VALUE_BITS:HALF_BITS] == '0)) begin
          i_r <= i_r + (VALUE_BITS + 1)'(1);
        end
      end
      S_MK_RD: begin
        if (j_r > lim_j) i_r <= i_r + (VALUE_BITS + 1)'(1);
      end
      S_MK_WT: j_r <= j_r + J_BITS'(i_r);
      S_START: begin
        x_r     <= item_r.value;
        cur_p_r <= '0;
        e_r     <= '0;
        n_r     <= '0;
        isp_r   <= 1'b0;
      end
      S_SINGLE: begin
        if (out_free) begin
          out_prime_factor   <= '0;
          out_exponent       <= '0;
          out_value_is_prime <= 1'b0;
          out_status         <= (item_r.kind == KIND_ONE) ? ST_ONE : ST_ERR;
          out_last           <= 1'b1;
        end
      end
      S_F_WT: begin
        if (!(need_emit && !out_free)) begin
          if (need_emit) begin
            out_prime_factor   <= cur_p_r;
            out_exponent       <= e_r;
            out_value_is_prime <= isp_r;
            out_status         <= ST_OK;
            out_last           <= fin_last;
            n_r                <= n_r + CNT_BITS'(1);
          end
          if (cur_p_r == '0) begin
            isp_r <= (rdata_r == item_r.value);
          end
          if (rdata_r == cur_p_r) begin
            e_r <= e_r + EXP_BITS'(1);
          end else begin
            cur_p_r <= rdata_r;
            e_r     <= EXP_BITS'(1);
          end
          dvd_r  <= x_r;
          rem_r  <= '0;
          dcnt_r <= '0;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (!rem_s[VALUE_BITS]) begin
          rem_r <= rem_s;
          dvd_r <= {dvd_r[VALUE_BITS-2:0], 1'b1};
        end else begin
          rem_r <= rem_t;
          dvd_r <= {dvd_r[VALUE_BITS-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + DIV_BITS'(1);
        if (dcnt_r == DIV_BITS'(VALUE_BITS - 1)) begin
          x_r <= {dvd_r[VALUE_BITS-2:0], !rem_s[VALUE_BITS]};
        end
      end
      default: ;
    endcase
  end

endmodule

[design/prime_factor_sieve_top.sv]
// Smallest-prime-factor sieve factorizer.
// Input channel (in_valid / in_stall / in_query_value): one query per
// transaction. Result channel (out_valid / out_stall / out_*): one
// transaction per distinct prime factor, ascending, out_last on the final
// one. A query of one gives one status-one result; zero or a value above
// the limit gives one error result.
// cfg_wr_en / cfg_wr_data write the sieve limit; write only while idle.
// Every limit write invalidates the table.
// The first query after reset or a limit write triggers a table build:
// a clear pass over table entries 0 through limit, then the sieve, which
// reads each entry and marks the multiples of each prime it finds.
// A factoring query reads the table and divides by each factor in the
// shared restoring divider: e prime factors with multiplicity take e+1
// reads and e divisions. One query is worked at a time; a two-deep
// queue keeps taking queries meanwhile until it is full.
// Reset (rst_n low, synchronous) empties the queue, drops the result
// register, sets the limit to all ones and marks the table unbuilt.
// A stalled result holds in the output register and the back end waits.
module prime_factor_sieve_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfs_pkg::VALUE_BITS-1:0] in_query_value,
  input  logic                           cfg_wr_en,
  input  logic [pfs_pkg::VALUE_BITS-1:0] cfg_wr_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfs_pkg::VALUE_BITS-1:0] out_prime_factor,
  output logic [pfs_pkg::EXP_BITS-1:0]   out_exponent,
  output logic                           out_value_is_prime,
  output logic [pfs_pkg::STAT_BITS-1:0]  out_status,
  output logic                           out_last
);
  import pfs_pkg::*;

`include "prime_factor_sieve_top_assert.svh"

  qitem_t   push_data, head;
  logic     push, pop, empty, full;
  cfg_ctl_t cfg_ctl;

  // front end: limit register and query classification
  pfs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_query_value (in_query_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_full         (full),
    .q_push         (push),
    .q_data         (push_data),
    .cfg_ctl        (cfg_ctl)
  );

  pfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // back end: table build, factoring, result register
  pfs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_ctl            (cfg_ctl),
    .q_head             (head),
    .q_empty            (empty),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_prime_factor   (out_prime_factor),
    .out_exponent       (out_exponent),
    .out_value_is_prime (out_value_is_prime),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  logic res_ok, res_err, ok_clean, err_clean;
  assign res_ok    = out_valid && (out_status == ST_OK);
  assign res_err   = out_valid && (out_status != ST_OK);
  assign ok_clean  = (out_prime_factor >= VALUE_BITS'(2)) && (out_exponent != '0);
  assign err_clean = out_last && (out_prime_factor == '0);

  // non-ok results are single and carry no factor
  `PFS_ASSERT_IMPL(a_err_last, clk, rst_n, res_err |-> err_clean, "non-ok result not single")
  // an ok result carries a real factor and exponent
  `PFS_ASSERT_IMPL(a_ok_factor, clk, rst_n, res_ok |-> ok_clean, "bad factor")
  // the queue never takes a push while full
  `PFS_ASSERT_CHK(a_q_push, clk, rst_n, full |-> !push, "push into full queue")

endmodule
